### sv/cbe_pkg.sv
package cbe_pkg;

    localparam int FRAC_BITS = 16;
    localparam int Q_W       = 20;
    localparam int CX_W      = 17;
    localparam int TOL_W     = 16;
    localparam int COEF_W    = 24;
    localparam int ACC_W     = 36;
    localparam int NUM_W     = ACC_W + FRAC_BITS;
    localparam int DIV_CW    = $clog2(NUM_W);
    localparam int TDATA_W   = ((Q_W + 7) / 8) * 8;
    localparam int CFG_AW    = 5;
    localparam int CFG_DW    = 32;

    localparam logic signed [Q_W-1:0] Q_ONE = Q_W'(64'd1 << FRAC_BITS);

    localparam logic [CX_W-1:0]  RST_P1X = CX_W'(27525);
    localparam logic [Q_W-1:0]   RST_P1Y = Q_W'(6554);
    localparam logic [CX_W-1:0]  RST_P2X = CX_W'(16384);
    localparam logic [Q_W-1:0]   RST_P2Y = Q_W'(65536);
    localparam logic [TOL_W-1:0] RST_TOL = TOL_W'(16);

    typedef enum logic [2:0] {
        REG_P1X,
        REG_P1Y,
        REG_P2X,
        REG_P2Y,
        REG_TOL
    } reg_idx_t;

    typedef struct packed {
        logic [CX_W-1:0]  p1x;
        logic [Q_W-1:0]   p1y;
        logic [CX_W-1:0]  p2x;
        logic [Q_W-1:0]   p2y;
        logic [TOL_W-1:0] tol;
    } cfg_t;

    typedef enum logic [1:0] {
        LD_AX,
        LD_AX3,
        LD_AY
    } acc_sel_t;

    typedef enum logic [2:0] {
        ADD_ZERO,
        ADD_BX,
        ADD_BX2,
        ADD_CX,
        ADD_BY,
        ADD_CY
    } addend_sel_t;

    typedef enum logic [1:0] {
        OUT_ZERO,
        OUT_ONE,
        OUT_ACC
    } out_sel_t;

    typedef enum logic [1:0] {
        EV_NX,
        EV_NS,
        EV_BX,
        EV_Y
    } eval_mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_N_START,
        ST_EV_MUL,
        ST_EV_ADD,
        ST_N_ERR,
        ST_N_CHK,
        ST_N_SLOPE,
        ST_DIV,
        ST_N_UPD,
        ST_B_INIT,
        ST_B_START,
        ST_B_ERR,
        ST_B_CHK,
        ST_Y_START,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic        x_load;
        logic        coef_load;
        logic        acc_load;
        acc_sel_t    acc_sel;
        logic        mul_en;
        logic        add_en;
        addend_sel_t addend_sel;
        logic        err_load;
        logic        t_from_x;
        logic        div_start;
        logic        div_step;
        logic        t_newton;
        logic        bis_init;
        logic        bis_update;
        logic        out_load;
        out_sel_t    out_sel;
    } cmd_t;

    typedef struct packed {
        logic x_le_zero;
        logic x_ge_one;
        logic err_small;
        logic slope_zero;
        logic bis_open;
    } status_t;

endpackage

### sv/cbe_ctrl.sv
module cbe_ctrl import cbe_pkg::*; #(
    parameter int NEWTON_STEPS = 8,
    parameter int BISECT_STEPS = 24
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    output logic    m_tvalid,
    input  logic    m_tready,
    output cmd_t    cmd,
    input  status_t sts
);

    localparam int NCW = $clog2(NEWTON_STEPS + 2);
    localparam int BCW = $clog2(BISECT_STEPS + 2);

    state_t           state_reg, state_next;
    eval_mode_t       mode_reg, mode_next;
    out_sel_t         outsel_reg, outsel_next;
    logic [1:0]       step_reg, step_next;
    logic [NCW-1:0]   n_cnt_reg, n_cnt_next;
    logic [BCW-1:0]   b_cnt_reg, b_cnt_next;
    logic [DIV_CW-1:0] div_cnt_reg, div_cnt_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic             last_step;
    addend_sel_t      addend;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    assign last_step = (mode_reg == EV_NS) ? (step_reg == 2'd1) : (step_reg == 2'd2);

    always_comb begin
        unique case (mode_reg)
            EV_NX, EV_BX: begin
                addend = (step_reg == 2'd0) ? ADD_BX :
                         (step_reg == 2'd1) ? ADD_CX : ADD_ZERO;
            end
            EV_NS: begin
                addend = (step_reg == 2'd0) ? ADD_BX2 : ADD_CX;
            end
            EV_Y: begin
                addend = (step_reg == 2'd0) ? ADD_BY :
                         (step_reg == 2'd1) ? ADD_CY : ADD_ZERO;
            end
            default: begin
                addend = ADD_ZERO;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            mode_reg     <= EV_NX;
            outsel_reg   <= OUT_ZERO;
            step_reg     <= '0;
            n_cnt_reg    <= '0;
            b_cnt_reg    <= '0;
            div_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            outsel_reg   <= outsel_next;
            step_reg     <= step_next;
            n_cnt_reg    <= n_cnt_next;
            b_cnt_reg    <= b_cnt_next;
            div_cnt_reg  <= div_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        outsel_next    = outsel_reg;
        step_next      = step_reg;
        n_cnt_next     = n_cnt_reg;
        b_cnt_next     = b_cnt_reg;
        div_cnt_next   = div_cnt_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        cmd            = '0;
        cmd.acc_sel    = LD_AX;
        cmd.addend_sel = addend;
        cmd.out_sel    = outsel_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.x_load = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                cmd.coef_load = 1'b1;
                cmd.t_from_x  = 1'b1;
                n_cnt_next    = '0;
                if (sts.x_le_zero) begin
                    outsel_next = OUT_ZERO;
                    state_next  = ST_OUT;
                end else if (sts.x_ge_one) begin
                    outsel_next = OUT_ONE;
                    state_next  = ST_OUT;
                end else begin
                    state_next = ST_N_START;
                end
            end
            ST_N_START: begin
                if (n_cnt_reg == NCW'(NEWTON_STEPS)) begin
                    state_next = ST_B_INIT;
                end else begin
                    cmd.acc_load = 1'b1;
                    cmd.acc_sel  = LD_AX;
                    mode_next    = EV_NX;
                    step_next    = '0;
                    state_next   = ST_EV_MUL;
                end
            end
            ST_EV_MUL: begin
                cmd.mul_en = 1'b1;
                state_next = ST_EV_ADD;
            end
            ST_EV_ADD: begin
                cmd.add_en = 1'b1;
                step_next  = step_reg + 2'd1;
                if (!last_step) begin
                    state_next = ST_EV_MUL;
                end else begin
                    unique case (mode_reg)
                        EV_NX: state_next = ST_N_ERR;
                        EV_NS: state_next = ST_N_SLOPE;
                        EV_BX: state_next = ST_B_ERR;
                        EV_Y: begin
                            outsel_next = OUT_ACC;
                            state_next  = ST_OUT;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_N_ERR: begin
                cmd.err_load = 1'b1;
                state_next   = ST_N_CHK;
            end
            ST_N_CHK: begin
                if (sts.err_small) begin
                    state_next = ST_Y_START;
                end else begin
                    cmd.acc_load = 1'b1;
                    cmd.acc_sel  = LD_AX3;
                    mode_next    = EV_NS;
                    step_next    = '0;
                    state_next   = ST_EV_MUL;
                end
            end
            ST_N_SLOPE: begin
                if (sts.slope_zero) begin
                    state_next = ST_B_INIT;
                end else begin
                    cmd.div_start = 1'b1;
                    div_cnt_next  = '0;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + DIV_CW'(1);
                if (div_cnt_reg == DIV_CW'(NUM_W - 1)) begin
                    state_next = ST_N_UPD;
                end
            end
            ST_N_UPD: begin
                cmd.t_newton = 1'b1;
                n_cnt_next   = n_cnt_reg + NCW'(1);
                state_next   = ST_N_START;
            end
            ST_B_INIT: begin
                cmd.bis_init = 1'b1;
                b_cnt_next   = '0;
                state_next   = ST_B_START;
            end
            ST_B_START: begin
                if (b_cnt_reg == BCW'(BISECT_STEPS) || !sts.bis_open) begin
                    state_next = ST_Y_START;
                end else begin
                    cmd.acc_load = 1'b1;
                    cmd.acc_sel  = LD_AX;
                    mode_next    = EV_BX;
                    step_next    = '0;
                    state_next   = ST_EV_MUL;
                end
            end
            ST_B_ERR: begin
                cmd.err_load = 1'b1;
                state_next   = ST_B_CHK;
            end
            ST_B_CHK: begin
                if (sts.err_small) begin
                    state_next = ST_Y_START;
                end else begin
                    cmd.bis_update = 1'b1;
                    b_cnt_next     = b_cnt_reg + BCW'(1);
                    state_next     = ST_B_START;
                end
            end
            ST_Y_START: begin
                cmd.acc_load = 1'b1;
                cmd.acc_sel  = LD_AY;
                mode_next    = EV_Y;
                step_next    = '0;
                state_next   = ST_EV_MUL;
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### sv/cbe_datapath.sv
module cbe_datapath import cbe_pkg::*; (
    input  logic                 aclk,
    input  cfg_t                 cfg,
    input  cmd_t                 cmd,
    output status_t              sts,
    input  logic signed [Q_W-1:0] x_in,
    output logic signed [Q_W-1:0] y_out
);

    localparam int DW = NUM_W + 2;
    localparam logic signed [DW-1:0] LIM_HI = $signed({{(DW-Q_W+1){1'b0}}, {(Q_W-1){1'b1}}});
    localparam logic signed [DW-1:0] LIM_LO = $signed({{(DW-Q_W+1){1'b1}}, {(Q_W-1){1'b0}}});

    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [DW-1:0] v);
        logic signed [Q_W-1:0] r;
        if (v > LIM_HI) begin
            r = LIM_HI[Q_W-1:0];
        end else if (v < LIM_LO) begin
            r = LIM_LO[Q_W-1:0];
        end else begin
            r = v[Q_W-1:0];
        end
        return r;
    endfunction

    logic signed [Q_W-1:0]       x_reg, t_reg, y_reg;
    logic signed [COEF_W-1:0]    ax_reg, bx_reg, cx_reg, ay_reg, by_reg, cy_reg;
    logic signed [COEF_W-1:0]    ax_next, bx_next, cx_next, ay_next, by_next, cy_next;
    logic signed [COEF_W-1:0]    p1x, p2x, p1y, p2y, dx, dy;
    logic signed [ACC_W-1:0]     acc_reg, err_reg, addend, ax_ext;
    logic signed [ACC_W+Q_W-1:0] prod_reg;
    logic [ACC_W-1:0]            err_mag, acc_mag, rem_reg, dvs_reg;
    logic [NUM_W-1:0]            quo_reg;
    logic                        neg_reg;
    logic [ACC_W:0]              rem_shift, rem_diff;
    logic                        rem_ge;
    logic signed [DW-1:0]        quot, t_diff;
    logic [FRAC_BITS:0]          lo_reg, hi_reg, lo_new, hi_new, t_pos;
    logic [FRAC_BITS+1:0]        mid_sum;

    assign p1x = $signed({{(COEF_W-CX_W){1'b0}}, cfg.p1x});
    assign p2x = $signed({{(COEF_W-CX_W){1'b0}}, cfg.p2x});
    assign p1y = $signed({{(COEF_W-Q_W){cfg.p1y[Q_W-1]}}, cfg.p1y});
    assign p2y = $signed({{(COEF_W-Q_W){cfg.p2y[Q_W-1]}}, cfg.p2y});
    assign dx  = p2x - p1x;
    assign dy  = p2y - p1y;

    assign cx_next = (p1x <<< 1) + p1x;
    assign bx_next = (dx <<< 1) + dx - cx_next;
    assign ax_next = COEF_W'(Q_ONE) - cx_next - bx_next;
    assign cy_next = (p1y <<< 1) + p1y;
    assign by_next = (dy <<< 1) + dy - cy_next;
    assign ay_next = COEF_W'(Q_ONE) - cy_next - by_next;

    assign ax_ext = ACC_W'(ax_reg);

    always_comb begin
        unique case (cmd.addend_sel)
            ADD_BX:  addend = ACC_W'(bx_reg);
            ADD_BX2: addend = ACC_W'(bx_reg) <<< 1;
            ADD_CX:  addend = ACC_W'(cx_reg);
            ADD_BY:  addend = ACC_W'(by_reg);
            ADD_CY:  addend = ACC_W'(cy_reg);
            default: addend = '0;
        endcase
    end

    assign err_mag = err_reg[ACC_W-1] ? ACC_W'(-err_reg) : ACC_W'(err_reg);
    assign acc_mag = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);

    assign rem_shift = {rem_reg, quo_reg[NUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, dvs_reg};
    assign rem_ge    = (rem_shift >= {1'b0, dvs_reg});

    assign quot   = neg_reg ? -$signed({2'b00, quo_reg}) : $signed({2'b00, quo_reg});
    assign t_diff = DW'(t_reg) - quot;

    assign t_pos   = t_reg[FRAC_BITS:0];
    assign lo_new  = err_reg[ACC_W-1] ? t_pos : lo_reg;
    assign hi_new  = err_reg[ACC_W-1] ? hi_reg : t_pos;
    assign mid_sum = {1'b0, lo_new} + {1'b0, hi_new};

    assign sts.x_le_zero  = x_reg[Q_W-1] || (x_reg == '0);
    assign sts.x_ge_one   = (x_reg >= Q_ONE);
    assign sts.err_small  = (err_mag < ACC_W'(cfg.tol));
    assign sts.slope_zero = (acc_reg == '0);
    assign sts.bis_open   = (lo_reg < hi_reg);

    assign y_out = y_reg;

    always_ff @(posedge aclk) begin
        if (cmd.x_load) begin
            x_reg <= x_in;
        end
        if (cmd.coef_load) begin
            ax_reg <= ax_next;
            bx_reg <= bx_next;
            cx_reg <= cx_next;
            ay_reg <= ay_next;
            by_reg <= by_next;
            cy_reg <= cy_next;
        end
        if (cmd.acc_load) begin
            unique case (cmd.acc_sel)
                LD_AX:   acc_reg <= ax_ext;
                LD_AX3:  acc_reg <= (ax_ext <<< 1) + ax_ext;
                LD_AY:   acc_reg <= ACC_W'(ay_reg);
                default: acc_reg <= '0;
            endcase
        end else if (cmd.add_en) begin
            acc_reg <= $signed(prod_reg[FRAC_BITS+ACC_W-1:FRAC_BITS]) + addend;
        end
        if (cmd.mul_en) begin
            prod_reg <= acc_reg * t_reg;
        end
        if (cmd.err_load) begin
            err_reg <= acc_reg - ACC_W'(x_reg);
        end
        if (cmd.div_start) begin
            neg_reg <= err_reg[ACC_W-1] ^ acc_reg[ACC_W-1];
            quo_reg <= NUM_W'(err_mag) << FRAC_BITS;
            rem_reg <= '0;
            dvs_reg <= acc_mag;
        end else if (cmd.div_step) begin
            rem_reg <= rem_ge ? rem_diff[ACC_W-1:0] : rem_shift[ACC_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], rem_ge};
        end
        if (cmd.bis_init) begin
            lo_reg <= '0;
            hi_reg <= Q_ONE[FRAC_BITS:0];
        end else if (cmd.bis_update) begin
            lo_reg <= lo_new;
            hi_reg <= hi_new;
        end
        priority if (cmd.t_from_x || cmd.bis_init) begin
            t_reg <= x_reg;
        end else if (cmd.t_newton) begin
            t_reg <= sat_q(t_diff);
        end else if (cmd.bis_update) begin
            t_reg <= $signed(Q_W'(mid_sum[FRAC_BITS+1:1]));
        end
        if (cmd.out_load) begin
            unique case (cmd.out_sel)
                OUT_ONE:  y_reg <= Q_ONE;
                OUT_ACC:  y_reg <= sat_q(DW'(acc_reg));
                default:  y_reg <= '0;
            endcase
        end
    end

endmodule

### sv/cubic_bezier_easing_eval.sv
// Unit cubic Bezier easing curve evaluator, end points (0,0) and (1,1).
// Input stream s_*: one progress value x per transfer, signed Q4.16.
// Output stream m_*: one curve value y per input transfer, signed Q4.16.
// The APB port holds the two control points and the solver tolerance; write
// it only while no item is in flight.
// One item is processed at a time; s_tready is high only while idle.
// An x at or below 0 or at or above 1 skips the solver: the setup state
// passes it straight to the output state. Otherwise the result waits on the
// solver loops: each polynomial evaluation runs a multiply state and an add
// state per term on one shared multiplier, and each Newton step adds a
// radix-2 divider. With the default limits, up to 8 Newton steps run and
// then, unless the error is already within the tolerance, up to 24 bisection steps.
// The result sits in an output register; while the receiver stalls it is
// held, and the next input is still taken and solved, waiting at the end
// until the register is free.
// Synchronous reset clears the controller and restores the reset values of
// the configuration registers; no result is pending after reset.
module cubic_bezier_easing_eval import cbe_pkg::*; #(
    parameter int NEWTON_STEPS = 8,
    parameter int BISECT_STEPS = 24
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // [19:0] x_in
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [19:0] y_out
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [CFG_AW-1:0]  paddr,
    input  logic [CFG_DW-1:0]  pwdata,
    output logic [CFG_DW-1:0]  prdata,
    output logic               pready
);

    cfg_t                  cfg_reg;
    cmd_t                  cmd;
    status_t               sts;
    reg_idx_t              reg_idx;
    logic                  cfg_wr;
    logic signed [Q_W-1:0] y_out;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = reg_idx_t'(paddr[CFG_AW-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.p1x <= RST_P1X;
            cfg_reg.p1y <= RST_P1Y;
            cfg_reg.p2x <= RST_P2X;
            cfg_reg.p2y <= RST_P2Y;
            cfg_reg.tol <= RST_TOL;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_P1X: cfg_reg.p1x <= pwdata[CX_W-1:0];
                REG_P1Y: cfg_reg.p1y <= pwdata[Q_W-1:0];
                REG_P2X: cfg_reg.p2x <= pwdata[CX_W-1:0];
                REG_P2Y: cfg_reg.p2y <= pwdata[Q_W-1:0];
                REG_TOL: cfg_reg.tol <= pwdata[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_P1X: prdata = CFG_DW'(cfg_reg.p1x);
            REG_P1Y: prdata = CFG_DW'(cfg_reg.p1y);
            REG_P2X: prdata = CFG_DW'(cfg_reg.p2x);
            REG_P2Y: prdata = CFG_DW'(cfg_reg.p2y);
            REG_TOL: prdata = CFG_DW'(cfg_reg.tol);
            default: prdata = '0;
        endcase
    end

    cbe_ctrl #(
        .NEWTON_STEPS (NEWTON_STEPS),
        .BISECT_STEPS (BISECT_STEPS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    cbe_datapath u_datapath (
        .aclk  (aclk),
        .cfg   (cfg_reg),
        .cmd   (cmd),
        .sts   (sts),
        .x_in  ($signed(s_tdata[Q_W-1:0])),
        .y_out (y_out)
    );

    assign m_tdata = {{(TDATA_W-Q_W){1'b0}}, y_out};

endmodule

### sv/cbe_props.sv
module cbe_props import cbe_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Stalled output transfer changed or dropped.");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[TDATA_W-1:Q_W] == '0)
        else $error("Output padding bits are not zero.");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("Output valid after reset.");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("Input taken while an item is being solved.");

endmodule

bind cubic_bezier_easing_eval cbe_props u_props (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
